// ----- design/poc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poc_pkg
// Shared types and constants of the proximity offset calibrator.
// ----------------------------------------------------------------------------
package poc_pkg;

    localparam int DATA_W    = 16;
    localparam int IDX_W     = 4;
    localparam int ACC_W     = 32;
    localparam int DIV_STEPS = ACC_W;

    typedef enum logic [1:0] {
        REQ_SAMPLE = 2'd0,
        REQ_SET    = 2'd1,
        REQ_START  = 2'd2,
        REQ_READ   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_FAIL = 2'd1,
        STAT_BUSY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ACC,
        ST_CORR,
        ST_MEAN_RD,
        ST_MEAN_DIV,
        ST_MEAN_WAIT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic              start;
        logic [ACC_W-1:0]  dividend;
        logic [DATA_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [ACC_W-1:0] quotient;
    } t_div_rsp;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [ACC_W-1:0] data;
    } t_acc_wr;

endpackage

// ----- design/proximity_offset_calibrator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// proximity_offset_calibrator_unit
// Per-sensor offset correction and averaging auto-calibration.
// ----------------------------------------------------------------------------
// One result beat leaves for every input beat. A sample with a valid index
// waits for the bit-serial divider (32 steps) that rescales (v - off) * FULL
// / (FULL - off); a set, read or start command, or a sample with a bad index,
// skips the divider. The sample that completes a calibration also passes
// each sensor's mean through the same divider in turn. One item is in flight
// at a time; the next input beat is taken while the previous result still
// waits at the output register.
// ----------------------------------------------------------------------------
module proximity_offset_calibrator_unit #(
    parameter int NUM_SENSORS = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // sensor_index[3:0], item_value[19:4], zero
    input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
    input  logic        s_axis_tlast,  // end_of_sweep
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // corrected_value[15:0], status[17:16],
                                       // offset_value[33:18], calibration_done[34]
);

    localparam int AW = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
    localparam logic [poc_pkg::DATA_W-1:0] FULL =
        poc_pkg::DATA_W'((33'd1 << SAMPLE_BITS) - 33'd1);

    poc_pkg::t_state  r_state, n_state;
    poc_pkg::t_req    r_req;
    poc_pkg::t_status r_status, n_status;

    logic [poc_pkg::IDX_W-1:0]  r_idx;
    logic [poc_pkg::DATA_W-1:0] r_val;
    logic                       r_eos;
    logic [poc_pkg::DATA_W-1:0] r_corr, n_corr;
    logic                       r_done, n_done;
    logic [poc_pkg::DATA_W-1:0] r_target, n_target;
    logic [poc_pkg::DATA_W-1:0] r_sweep, n_sweep;
    logic [AW-1:0]              r_mi, n_mi;
    logic [poc_pkg::DATA_W-1:0] r_offset [NUM_SENSORS];
    logic                       r_m_valid;
    logic [39:0]                r_m_data;

    logic                       accept;
    logic                       idx_ok;
    logic                       busy;
    logic [poc_pkg::DATA_W-1:0] off;
    logic [poc_pkg::DATA_W-1:0] raw;
    logic [poc_pkg::DATA_W-1:0] delta;
    logic [poc_pkg::ACC_W-1:0]  scaled;
    logic                       skip_div;
    logic [poc_pkg::DATA_W-1:0] sweep_inc;
    logic                       last_sweep;
    logic [poc_pkg::DATA_W-1:0] mean_sat;
    logic                       out_load;
    logic                       off_we;
    logic [AW-1:0]              off_waddr;
    logic [poc_pkg::DATA_W-1:0] off_wdata;
    logic                       acc_clear;
    logic [poc_pkg::IDX_W-1:0]  acc_rd_addr;
    logic [poc_pkg::ACC_W-1:0]  acc_rd_data;

    poc_pkg::t_div_req div_req;
    poc_pkg::t_div_rsp div_rsp;
    poc_pkg::t_acc_wr  acc_wr;

    poc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    poc_acc_mem #(
        .NUM_SENSORS (NUM_SENSORS)
    ) u_acc_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (acc_wr),
        .i_clear   (acc_clear),
        .i_rd_addr (acc_rd_addr),
        .o_rd_data (acc_rd_data)
    );

    assign accept     = s_axis_tvalid && s_axis_tready;
    assign idx_ok     = {1'b0, r_idx} < 5'(NUM_SENSORS);
    assign busy       = r_target != '0;
    assign off        = idx_ok ? r_offset[r_idx[AW-1:0]] : '0;
    assign raw        = r_val & FULL;
    assign skip_div   = (off >= FULL) || (raw <= off);
    assign delta      = raw - off;
    // delta * FULL as a shift and subtract
    assign scaled     = (poc_pkg::ACC_W'(delta) << SAMPLE_BITS) - poc_pkg::ACC_W'(delta);
    assign sweep_inc  = r_sweep + 1'b1;
    assign last_sweep = busy && r_eos && (sweep_inc == r_target);
    assign mean_sat   = (|div_rsp.quotient[poc_pkg::ACC_W-1:poc_pkg::DATA_W])
                        ? '1 : div_rsp.quotient[poc_pkg::DATA_W-1:0];
    assign acc_rd_addr = (r_state == poc_pkg::ST_MEAN_RD)
                         ? poc_pkg::IDX_W'(r_mi) : r_idx;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            poc_pkg::ST_IDLE: begin
                if (s_axis_tvalid) n_state = poc_pkg::ST_LOAD;
            end
            poc_pkg::ST_LOAD: begin
                if (r_req == poc_pkg::REQ_SAMPLE && idx_ok) n_state = poc_pkg::ST_ACC;
                else n_state = poc_pkg::ST_OUT;
            end
            poc_pkg::ST_ACC: begin
                n_state = poc_pkg::ST_CORR;
            end
            poc_pkg::ST_CORR: begin
                if (div_rsp.done) begin
                    n_state = last_sweep ? poc_pkg::ST_MEAN_RD : poc_pkg::ST_OUT;
                end
            end
            poc_pkg::ST_MEAN_RD: begin
                n_state = poc_pkg::ST_MEAN_DIV;
            end
            poc_pkg::ST_MEAN_DIV: begin
                n_state = poc_pkg::ST_MEAN_WAIT;
            end
            poc_pkg::ST_MEAN_WAIT: begin
                if (div_rsp.done) begin
                    n_state = (r_mi == AW'(NUM_SENSORS - 1))
                              ? poc_pkg::ST_OUT : poc_pkg::ST_MEAN_RD;
                end
            end
            poc_pkg::ST_OUT: begin
                if (!r_m_valid || m_axis_tready) n_state = poc_pkg::ST_IDLE;
            end
            default: n_state = poc_pkg::ST_IDLE;
        endcase
    end

    // datapath control
    always_comb begin
        s_axis_tready    = 1'b0;
        n_status         = r_status;
        n_corr           = r_corr;
        n_done           = r_done;
        n_target         = r_target;
        n_sweep          = r_sweep;
        n_mi             = r_mi;
        out_load         = 1'b0;
        off_we           = 1'b0;
        off_waddr        = r_idx[AW-1:0];
        off_wdata        = r_val;
        acc_clear        = 1'b0;
        acc_wr.en        = 1'b0;
        acc_wr.addr      = r_idx;
        acc_wr.data      = acc_rd_data + poc_pkg::ACC_W'(raw);
        div_req.start    = 1'b0;
        div_req.dividend = skip_div ? '0 : scaled;
        div_req.divisor  = skip_div ? poc_pkg::DATA_W'(1) : (FULL - off);
        case (r_state)
            poc_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
            end
            poc_pkg::ST_LOAD: begin
                n_status = poc_pkg::STAT_OK;
                n_corr   = '0;
                n_done   = 1'b0;
                if (r_req == poc_pkg::REQ_SAMPLE) begin
                    if (!idx_ok) n_status = poc_pkg::STAT_FAIL;
                end else if (busy) begin
                    n_status = poc_pkg::STAT_BUSY;
                end else if (r_req == poc_pkg::REQ_SET) begin
                    if (idx_ok) off_we = 1'b1;
                    else n_status = poc_pkg::STAT_FAIL;
                end else if (r_req == poc_pkg::REQ_START) begin
                    acc_clear = 1'b1;
                    n_target  = r_val;
                    n_sweep   = '0;
                end else begin
                    if (!idx_ok) n_status = poc_pkg::STAT_FAIL;
                end
            end
            poc_pkg::ST_ACC: begin
                // full-scale offsets and samples at or below the offset divide zero by one
                acc_wr.en     = busy;
                div_req.start = 1'b1;
            end
            poc_pkg::ST_CORR: begin
                if (div_rsp.done) begin
                    n_corr = div_rsp.quotient[poc_pkg::DATA_W-1:0];
                    if (busy && r_eos) n_sweep = sweep_inc;
                    n_mi = '0;
                end
            end
            poc_pkg::ST_MEAN_DIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = acc_rd_data;
                div_req.divisor  = r_target;
            end
            poc_pkg::ST_MEAN_WAIT: begin
                if (div_rsp.done) begin
                    off_we    = 1'b1;
                    off_waddr = r_mi;
                    off_wdata = mean_sat;
                    n_mi      = r_mi + 1'b1;
                    if (r_mi == AW'(NUM_SENSORS - 1)) begin
                        n_target = '0;
                        n_sweep  = '0;
                        n_done   = 1'b1;
                    end
                end
            end
            poc_pkg::ST_OUT: begin
                out_load = !r_m_valid || m_axis_tready;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= poc_pkg::ST_IDLE;
            r_target  <= '0;
            r_sweep   <= '0;
            r_m_valid <= 1'b0;
            for (int i = 0; i < NUM_SENSORS; i++) begin
                r_offset[i] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_target <= n_target;
            r_sweep  <= n_sweep;
            if (off_we) r_offset[off_waddr] <= off_wdata;
            if (out_load) r_m_valid <= 1'b1;
            else if (m_axis_tready) r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= poc_pkg::t_req'(s_axis_tuser);
            r_idx <= s_axis_tdata[3:0];
            r_val <= s_axis_tdata[19:4];
            r_eos <= s_axis_tlast;
        end
        r_status <= n_status;
        r_corr   <= n_corr;
        r_done   <= n_done;
        r_mi     <= n_mi;
        if (out_load) begin
            r_m_data <= {5'b0, r_done, off, r_status, r_corr};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

// ----- design/poc_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poc_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module poc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  poc_pkg::t_div_req i_req,
    output poc_pkg::t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(poc_pkg::DIV_STEPS);

    logic                         r_busy;
    logic                         r_done;
    logic [CNT_W-1:0]             r_cnt;
    logic [poc_pkg::DATA_W-1:0]   r_rem;
    logic [poc_pkg::DATA_W-1:0]   r_dvs;
    logic [poc_pkg::ACC_W-1:0]    r_num;
    logic [poc_pkg::DATA_W:0]     trial;
    logic [poc_pkg::DATA_W:0]     diff;
    logic                         ge;

    // dividend bits shift out at the top, quotient bits shift in at the bottom
    assign trial = {r_rem, r_num[poc_pkg::ACC_W-1]};
    assign ge    = trial >= {1'b0, r_dvs};
    assign diff  = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(poc_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.dividend;
            r_dvs <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[poc_pkg::DATA_W-1:0] : trial[poc_pkg::DATA_W-1:0];
            r_num <= {r_num[poc_pkg::ACC_W-2:0], ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_num;

endmodule

// ----- design/poc_acc_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poc_acc_mem
// Per-sensor accumulator memory with valid bits so that a clear resets every entry at once.
// ----------------------------------------------------------------------------
module poc_acc_mem #(
    parameter int NUM_SENSORS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  poc_pkg::t_acc_wr            i_wr,
    input  logic                        i_clear,
    input  logic [poc_pkg::IDX_W-1:0]   i_rd_addr,
    output logic [poc_pkg::ACC_W-1:0]   o_rd_data
);

    localparam int AW = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

    logic [poc_pkg::ACC_W-1:0] r_mem [NUM_SENSORS];
    logic [NUM_SENSORS-1:0]    r_vld;
    logic [poc_pkg::ACC_W-1:0] r_rd_data;
    logic                      r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_clear) begin
                r_vld <= '0;
            end else if (i_wr.en) begin
                r_vld[i_wr.addr[AW-1:0]] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_rd_addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr[AW-1:0]] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr[AW-1:0]];
    end

    // entries not written since the last clear read as zero
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the proximity offset calibrator: a scoreboard class
// mirrors the offset table, accumulators and sweep counter and predicts every
// result beat, while random gaps and stalls load both stream sides.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          NUM_SENSORS  = 8;
    localparam int          SAMPLE_BITS  = 16;
    localparam logic [31:0] FULL         = (32'd1 << SAMPLE_BITS) - 32'd1;
    localparam int          N_ITEMS      = 750;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES = 50;
    localparam int          LIMIT_CYCLES = 1_000_000;

    typedef struct {
        logic [15:0]      corrected;
        poc_pkg::t_status status;
        logic [15:0]      offset;
        logic             done;
    } t_poc_result;

    class offset_scoreboard;
        logic [15:0]  offsets [NUM_SENSORS];
        logic [31:0]  accums [NUM_SENSORS];
        logic [15:0]  target_sweeps;
        logic [15:0]  sweep_cnt;
        t_poc_result  pending_q [$];
        int           errors, n_checked;
        int           n_samples, n_cmds, n_cals, n_busy, n_fail;

        function new();
            for (int i = 0; i < NUM_SENSORS; i++) begin
                offsets[i] = '0;
                accums[i]  = '0;
            end
            target_sweeps = '0;
            sweep_cnt     = '0;
            errors = 0; n_checked = 0;
            n_samples = 0; n_cmds = 0; n_cals = 0; n_busy = 0; n_fail = 0;
        endfunction

        function logic [15:0] rescale(logic [31:0] raw, logic [31:0] off);
            logic [47:0] num;
            if (off >= FULL || raw <= off) return 16'd0;
            num = 48'(raw - off) * 48'(FULL);
            return 16'(num / 48'(FULL - off));
        endfunction

        function void note_input(poc_pkg::t_req req, logic [3:0] idx, logic [15:0] val,
                                 logic eos);
            t_poc_result r;
            logic        idx_ok, busy;
            logic [31:0] raw, mean;
            idx_ok      = idx < NUM_SENSORS;
            busy        = target_sweeps != 0;
            r.corrected = '0;
            r.status    = poc_pkg::STAT_OK;
            r.done      = 1'b0;
            if (req == poc_pkg::REQ_SAMPLE) begin
                n_samples++;
                if (!idx_ok) begin
                    r.status = poc_pkg::STAT_FAIL;
                end else begin
                    raw = 32'(val) & FULL;
                    if (busy) accums[idx] += raw;
                    // corrected with the offset in force before this beat
                    r.corrected = rescale(raw, 32'(offsets[idx]));
                    if (busy && eos) begin
                        sweep_cnt++;
                        if (sweep_cnt == target_sweeps) begin
                            for (int i = 0; i < NUM_SENSORS; i++) begin
                                mean = accums[i] / 32'(target_sweeps);
                                offsets[i] = (mean > 32'hFFFF) ? 16'hFFFF : mean[15:0];
                            end
                            target_sweeps = '0;
                            sweep_cnt     = '0;
                            r.done        = 1'b1;
                            n_cals++;
                        end
                    end
                end
            end else begin
                n_cmds++;
                if (busy) begin
                    r.status = poc_pkg::STAT_BUSY;
                end else if (req == poc_pkg::REQ_SET) begin
                    if (idx_ok) offsets[idx] = val;
                    else r.status = poc_pkg::STAT_FAIL;
                end else if (req == poc_pkg::REQ_START) begin
                    for (int i = 0; i < NUM_SENSORS; i++) accums[i] = '0;
                    target_sweeps = val;
                    sweep_cnt     = '0;
                end else if (!idx_ok) begin
                    r.status = poc_pkg::STAT_FAIL;
                end
            end
            if (r.status == poc_pkg::STAT_BUSY) n_busy++;
            if (r.status == poc_pkg::STAT_FAIL) n_fail++;
            r.offset = idx_ok ? offsets[idx] : 16'd0;
            pending_q.push_back(r);
        endfunction

        function void check_result(logic [39:0] beat);
            t_poc_result w;
            if (pending_q.size() == 0) begin
                $display("%0t: result beat with nothing expected, actual %h", $time, beat);
                errors++;
                return;
            end
            w = pending_q.pop_front();
            n_checked++;
            if (beat[15:0] !== w.corrected) begin
                $display("%0t: corrected_value expected %0d actual %0d",
                         $time, w.corrected, beat[15:0]);
                errors++;
            end
            if (beat[17:16] !== w.status) begin
                $display("%0t: status expected %0d actual %0d", $time, w.status, beat[17:16]);
                errors++;
            end
            if (beat[33:18] !== w.offset) begin
                $display("%0t: offset_value expected %0d actual %0d",
                         $time, w.offset, beat[33:18]);
                errors++;
            end
            if (beat[34] !== w.done) begin
                $display("%0t: calibration_done expected %0d actual %0d",
                         $time, w.done, beat[34]);
                errors++;
            end
            if (beat[39:35] !== 5'd0) begin
                $display("%0t: tdata padding expected 0 actual %h", $time, beat[39:35]);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // sensor_index[3:0], item_value[19:4], zero
    logic [1:0]  s_axis_tuser;   // req_type[1:0]
    logic        s_axis_tlast;   // end_of_sweep
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // corrected_value[15:0], status[17:16],
                                 // offset_value[33:18], calibration_done[34]

    offset_scoreboard sb;
    int               n_sent = 0;
    bit               tx_burst = 1'b0;

    proximity_offset_calibrator_unit #(
        .NUM_SENSORS(NUM_SENSORS),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_item(poc_pkg::t_req req, int idx, int val, bit eos);
        int gap;
        gap = tx_burst ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {4'd0, 16'(val), 4'(idx)};
        s_axis_tlast  <= eos;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(req, 4'(idx), 16'(val), eos);
        n_sent++;
    endtask

    // result side: random stalls, quiet stretches, and two long hold-offs
    initial begin
        int stall_left, hold_left, mode_cnt;
        bit quiet;
        stall_left = 0; hold_left = 0; mode_cnt = 0; quiet = 1'b0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata);
                if (sb.n_checked == 60 || sb.n_checked == 420) hold_left = HOLD_CYCLES;
            end
            if (mode_cnt == 0) begin
                quiet    = ($urandom_range(0, 3) == 0);
                mode_cnt = 64;
            end
            mode_cnt--;
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (!quiet && $urandom_range(0, 2) == 0) stall_left = 1 + pick_gap();
            end
        end
    end

    initial begin
        #(LIMIT_CYCLES * 4);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int            n_directed, sweeps, idx, val, r;
        logic [15:0]   base, off;
        poc_pkg::t_req req;
        sb = new();
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= poc_pkg::REQ_SAMPLE;
        s_axis_tlast  <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, every request, each corner of the correction
        send_item(poc_pkg::REQ_READ,   0, 0, 0);
        send_item(poc_pkg::REQ_SAMPLE, 0, 16'h0000, 0);
        send_item(poc_pkg::REQ_SAMPLE, 7, 16'hFFFF, 1);   // sweep end while idle is ignored
        send_item(poc_pkg::REQ_SET,    3, 1000, 0);
        send_item(poc_pkg::REQ_SAMPLE, 3, 1000, 0);       // equal to offset
        send_item(poc_pkg::REQ_SAMPLE, 3, 999, 0);        // below offset
        send_item(poc_pkg::REQ_SAMPLE, 3, 1001, 0);
        send_item(poc_pkg::REQ_SET,    5, 16'hFFFF, 0);
        send_item(poc_pkg::REQ_SAMPLE, 5, 16'hFFFF, 0);   // full-scale offset
        send_item(poc_pkg::REQ_SET,    8, 5, 0);          // bad index
        send_item(poc_pkg::REQ_READ,   15, 0, 1);
        send_item(poc_pkg::REQ_SAMPLE, 12, 1234, 1);      // bad index drops the beat
        send_item(poc_pkg::REQ_START,  9, 0, 0);          // zero sweeps only clears
        send_item(poc_pkg::REQ_START,  2, 1, 0);
        send_item(poc_pkg::REQ_SET,    0, 7, 0);          // busy
        send_item(poc_pkg::REQ_READ,   3, 0, 0);          // busy, still reports offset
        send_item(poc_pkg::REQ_START,  0, 3, 0);          // busy
        send_item(poc_pkg::REQ_SAMPLE, 10, 55, 1);        // bad index, no sweep count
        send_item(poc_pkg::REQ_SAMPLE, 0, 16'hFFFF, 0);
        send_item(poc_pkg::REQ_SAMPLE, 0, 16'hFFFF, 0);   // mean above full scale
        send_item(poc_pkg::REQ_SAMPLE, 1, 300, 1);        // completes the calibration
        send_item(poc_pkg::REQ_READ,   0, 0, 0);
        send_item(poc_pkg::REQ_SET,    5, 0, 0);
        n_directed = n_sent;

        while (n_sent < n_directed + N_ITEMS) begin
            tx_burst = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 99) < 35) begin
                // well-formed calibration: start, then sweeps over the sensors, a few of them short
                sweeps = $urandom_range(1, 4);
                send_item(poc_pkg::REQ_START, $urandom_range(0, 15), sweeps,
                          $urandom_range(0, 1));
                base = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4000));
                for (int s = 0; s < sweeps; s++) begin
                    bit short_sweep;
                    short_sweep = ($urandom_range(0, 9) == 0);
                    for (int k = 0; k < NUM_SENSORS; k++) begin
                        if (short_sweep && k < NUM_SENSORS - 1 && $urandom_range(0, 1)) continue;
                        if ($urandom_range(0, 9) == 0) begin
                            req = poc_pkg::t_req'($urandom_range(0, 3));
                            val = (req == poc_pkg::REQ_START) ? $urandom_range(0, 3) : $urandom;
                            send_item(req, $urandom_range(0, 15), val, $urandom_range(0, 1));
                        end
                        val = ($urandom_range(0, 6) == 0) ? $urandom
                                                         : base + $urandom_range(0, 200);
                        send_item(poc_pkg::REQ_SAMPLE, k, val, k == NUM_SENSORS - 1);
                    end
                end
            end else begin
                repeat ($urandom_range(1, 12)) begin
                    idx = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 15)
                                                     : $urandom_range(0, NUM_SENSORS - 1);
                    off = (idx < NUM_SENSORS) ? sb.offsets[idx] : 16'd0;
                    r   = $urandom_range(0, 99);
                    if (r < 50) begin
                        case ($urandom_range(0, 4))
                            0:       val = 16'(off + $urandom_range(0, 8));
                            1:       val = 16'(off - $urandom_range(0, 8));
                            2:       val = 0;
                            3:       val = 16'hFFFF;
                            default: val = $urandom;
                        endcase
                        send_item(poc_pkg::REQ_SAMPLE, idx, val, $urandom_range(0, 4) == 0);
                    end else if (r < 70) begin
                        case ($urandom_range(0, 3))
                            0:       val = ($urandom_range(0, 1) == 0) ? 0 : 16'hFFFF;
                            1:       val = $urandom_range(0, 3000);
                            default: val = $urandom;
                        endcase
                        send_item(poc_pkg::REQ_SET, idx, val, $urandom_range(0, 4) == 0);
                    end else if (r < 92) begin
                        send_item(poc_pkg::REQ_READ, idx, $urandom, $urandom_range(0, 4) == 0);
                    end else begin
                        send_item(poc_pkg::REQ_START, idx, 0, $urandom_range(0, 1));
                    end
                end
            end
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d beats: %0d samples, %0d commands, %0d calibrations completed",
                 n_sent, sb.n_samples, sb.n_cmds, sb.n_cals);
        $display("answers: %0d busy, %0d bad index, %0d results checked, %0d mismatches",
                 sb.n_busy, sb.n_fail, sb.n_checked, sb.errors);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
